// ----- src/i2c_eeprom_master_assert.svh -----
// Assertion macros for the EEPROM master
`ifndef I2C_EEPROM_MASTER_ASSERT_SVH
`define I2C_EEPROM_MASTER_ASSERT_SVH
`ifndef SYNTHESIS
`define IEM_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define IEM_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define IEM_ASSERT_IMP(label, clk, rst_n, a, b)
`define IEM_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- src/iem_pkg.sv -----
// ----------------------------------------------------------------------------
// iem_pkg
// Shared types and constants for the I2C EEPROM master.
// ----------------------------------------------------------------------------
package iem_pkg;
    localparam int ADDRESS_BITS_DEF = 16;
    localparam logic [6:0] DEV_ADDR_RST = 7'd80;
    localparam logic [7:0] ACK_TO_RST = 8'd250;
    localparam logic [9:0] POLL_LIM_RST = 10'd1000;

    localparam logic [1:0] REG_DEV = 2'd0;
    localparam logic [1:0] REG_ACKTO = 2'd1;
    localparam logic [1:0] REG_POLL = 2'd2;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_POLL = 2'd3;

    localparam logic [1:0] STAT_OK = 2'd0;
    localparam logic [1:0] STAT_TIMEOUT = 2'd1;
    localparam logic [1:0] STAT_POLLFAIL = 2'd2;

    typedef struct packed {
        logic [6:0] dev;
        logic [7:0] ack_to;
        logic [9:0] poll_lim;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] mem_addr;
        logic [15:0] read_count;
        logic [7:0]  write_data;
        logic        sda_in;
    } item_t;

    typedef struct packed {
        logic        scl_out;
        logic        sda_out;
        logic        busy_res;
        logic        byte_valid;
        logic [7:0]  read_byte;
        logic        last_byte;
        logic        done_res;
        logic [1:0]  status;
    } result_t;
endpackage

// ----- src/iem_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// iem_cfg_regs
// Configuration register file.
// ----------------------------------------------------------------------------
module iem_cfg_regs
    import iem_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic [1:0] cfg_index,
    input  logic [9:0] cfg_data,
    output cfg_t       cfg
);
    cfg_t cfg_reg;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dev <= DEV_ADDR_RST;
            cfg_reg.ack_to <= ACK_TO_RST;
            cfg_reg.poll_lim <= POLL_LIM_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEV:   cfg_reg.dev <= cfg_data[6:0];
                REG_ACKTO: cfg_reg.ack_to <= cfg_data[7:0];
                REG_POLL:  cfg_reg.poll_lim <= cfg_data;
                default:   ;
            endcase
        end
    end
endmodule

// ----- src/iem_engine.sv -----
// ----------------------------------------------------------------------------
// iem_engine
// Bus phase sequencer: one accepted item advances one phase.
// ----------------------------------------------------------------------------
module iem_engine
    import iem_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);
    typedef enum logic [4:0] {
        S_IDLE, S_R_START, S_R_DEVW, S_R_ACK_DEVW, S_R_AHI, S_R_ACK_AHI,
        S_R_ALO, S_R_ACK_ALO, S_R_RESTART, S_R_DEVR, S_R_ACK_DEVR, S_R_BYTE,
        S_R_MACK, S_W_START, S_W_DEVW, S_W_ACK_DEVW, S_W_AHI, S_W_ACK_AHI,
        S_W_ALO, S_W_ACK_ALO, S_W_DATA, S_W_ACK_DATA, S_P_START, S_P_DEVW,
        S_P_ACK, S_STOP_OK, S_STOP_TIMEOUT, S_STOP_POLLFAIL, S_STOP_RETRY_W,
        S_STOP_RETRY_P
    } step_t;
    typedef enum logic [2:0] {K_NONE, K_START, K_STOP, K_SEND, K_ACK, K_READ,
        K_MACK} kind_t;

    localparam bit HI = ADDRESS_BITS > 8;

    step_t       st_reg, st_next;
    logic [1:0]  pc_reg, pc_next;
    logic [2:0]  bi_reg, bi_next;
    logic [7:0]  sh_reg, sh_next;
    logic [ADDRESS_BITS-1:0] addr_reg, addr_next;
    logic [15:0] rem_reg, rem_next;
    logic [9:0]  tries_reg, tries_next;
    logic [7:0]  acks_reg, acks_next;
    logic [7:0]  pend_reg, pend_next;
    logic        scl_reg, scl_next, sda_reg, sda_next;
    result_t     res_reg, res_next;
    logic [15:0] addr16;

    assign res = res_reg;
    assign addr16 = 16'(addr_reg);

    function automatic kind_t kind_of(step_t s);
        case (s)
            S_R_START, S_R_RESTART, S_W_START, S_P_START: return K_START;
            S_R_DEVW, S_R_AHI, S_R_ALO, S_R_DEVR, S_W_DEVW, S_W_AHI, S_W_ALO,
            S_W_DATA, S_P_DEVW: return K_SEND;
            S_R_ACK_DEVW, S_R_ACK_AHI, S_R_ACK_ALO, S_R_ACK_DEVR, S_W_ACK_DEVW,
            S_W_ACK_AHI, S_W_ACK_ALO, S_W_ACK_DATA, S_P_ACK: return K_ACK;
            S_R_BYTE: return K_READ;
            S_R_MACK: return K_MACK;
            S_STOP_OK, S_STOP_TIMEOUT, S_STOP_POLLFAIL, S_STOP_RETRY_W,
            S_STOP_RETRY_P: return K_STOP;
            default: return K_NONE;
        endcase
    endfunction

    always_comb
    begin
        step_t s, ns;
        logic [1:0] nxt;
        logic fin, fail, run;
        logic [15:0] rem_v;
        logic [ADDRESS_BITS-1:0] addr_v;
        logic [7:0] sh_v;
        logic [9:0] tr_v;
        st_next = st_reg; pc_next = pc_reg; bi_next = bi_reg; sh_next = sh_reg;
        addr_next = addr_reg; rem_next = rem_reg; tries_next = tries_reg;
        acks_next = acks_reg; pend_next = pend_reg;
        scl_next = scl_reg; sda_next = sda_reg;
        res_next = '0;
        fin = 1'b0; fail = 1'b0; run = 1'b0; ns = S_IDLE;
        s = st_reg; nxt = 2'(pc_reg + 2'd1);
        rem_v = rem_reg; addr_v = addr_reg; sh_v = sh_reg; tr_v = tries_reg;
        if (st_reg == S_IDLE)
        begin
            if (item.mode != MODE_TICK)
            begin
                addr_v = item.mem_addr[ADDRESS_BITS-1:0];
                rem_v = item.read_count;
                pend_next = item.write_data;
                tr_v = '0;
                s = (item.mode == MODE_READ) ? S_R_START :
                    (item.mode == MODE_WRITE) ? S_W_START : S_P_START;
                nxt = 2'd1;
                run = 1'b1;
                bi_next = '0; acks_next = '0;
            end
        end
        else
            run = 1'b1;
        if (run)
        begin
            logic [1:0] pc;
            pc = (st_reg == S_IDLE) ? 2'd0 : pc_reg;
            case (kind_of(s))
                K_START:
                    case (pc)
                        2'd0: sda_next = 1'b1;
                        2'd1: scl_next = 1'b1;
                        2'd2: sda_next = 1'b0;
                        default: begin scl_next = 1'b0; fin = 1'b1; end
                    endcase
                K_STOP:
                    case (pc)
                        2'd0: scl_next = 1'b0;
                        2'd1: sda_next = 1'b0;
                        2'd2: scl_next = 1'b1;
                        default: begin sda_next = 1'b1; fin = 1'b1; end
                    endcase
                K_SEND:
                    case (pc)
                        2'd0: begin scl_next = 1'b0; sda_next = sh_v[7]; end
                        2'd1: scl_next = 1'b1;
                        2'd2:
                        begin
                            scl_next = 1'b0;
                            if (bi_reg != 3'd7)
                            begin
                                sh_v = {sh_v[6:0], 1'b0};
                                bi_next = 3'(bi_reg + 3'd1);
                                nxt = 2'd0;
                            end
                        end
                        default: begin sda_next = 1'b1; fin = 1'b1; end
                    endcase
                K_ACK:
                    case (pc)
                        2'd0: sda_next = 1'b1;
                        2'd1:
                        begin
                            scl_next = 1'b1; sda_next = 1'b1;
                            if (!item.sda_in) nxt = 2'd2;
                            else if (acks_reg >= cfg.ack_to) fail = 1'b1;
                            else
                            begin
                                acks_next = 8'(acks_reg + 8'd1);
                                nxt = 2'd1;
                            end
                        end
                        default: begin scl_next = 1'b0; fin = 1'b1; end
                    endcase
                K_READ:
                    if (pc == 2'd0)
                    begin
                        scl_next = 1'b1; sda_next = 1'b1;
                        sh_v = {sh_v[6:0], item.sda_in};
                        if (bi_reg == 3'd7)
                        begin
                            res_next.byte_valid = 1'b1;
                            res_next.read_byte = sh_v;
                            res_next.last_byte = (rem_v == 16'd1);
                        end
                    end
                    else
                    begin
                        scl_next = 1'b0;
                        if (bi_reg != 3'd7)
                        begin
                            bi_next = 3'(bi_reg + 3'd1);
                            nxt = 2'd0;
                        end
                        else fin = 1'b1;
                    end
                K_MACK:
                    if (rem_v > 16'd1)
                        case (pc)
                            2'd0: sda_next = 1'b0;
                            2'd1: scl_next = 1'b1;
                            2'd2: scl_next = 1'b0;
                            default: begin sda_next = 1'b1; fin = 1'b1; end
                        endcase
                    else
                        case (pc)
                            2'd0: sda_next = 1'b1;
                            2'd1: scl_next = 1'b1;
                            default: begin scl_next = 1'b0; fin = 1'b1; end
                        endcase
                default: ;
            endcase
            pc_next = nxt;
            st_next = s;
            if (fail)
            begin
                if (s == S_W_ACK_DEVW || s == S_P_ACK)
                begin
                    tr_v = 10'(tr_v + 10'd1);
                    if (tr_v >= cfg.poll_lim) ns = S_STOP_POLLFAIL;
                    else ns = (s == S_W_ACK_DEVW) ? S_STOP_RETRY_W : S_STOP_RETRY_P;
                end
                else ns = S_STOP_TIMEOUT;
            end
            else if (fin)
            begin
                case (s)
                    S_R_ACK_DEVW: ns = HI ? S_R_AHI : S_R_ALO;
                    S_R_ACK_ALO: ns = S_R_RESTART;
                    S_R_ACK_DEVR: ns = (rem_v != 0) ? S_R_BYTE : S_STOP_OK;
                    S_R_BYTE: ns = S_R_MACK;
                    S_R_MACK:
                    begin
                        rem_v = 16'(rem_v - 16'd1);
                        addr_v = ADDRESS_BITS'(addr_v + 1'b1);
                        ns = (rem_v != 0) ? S_R_BYTE : S_STOP_OK;
                    end
                    S_W_ACK_DEVW: ns = HI ? S_W_AHI : S_W_ALO;
                    S_W_ACK_DATA, S_P_ACK: ns = S_STOP_OK;
                    S_STOP_OK:
                    begin
                        res_next.done_res = 1'b1; res_next.status = STAT_OK; ns = S_IDLE;
                    end
                    S_STOP_TIMEOUT:
                    begin
                        res_next.done_res = 1'b1; res_next.status = STAT_TIMEOUT;
                        ns = S_IDLE;
                    end
                    S_STOP_POLLFAIL:
                    begin
                        res_next.done_res = 1'b1; res_next.status = STAT_POLLFAIL;
                        ns = S_IDLE;
                    end
                    S_STOP_RETRY_W: ns = S_W_START;
                    S_STOP_RETRY_P: ns = S_P_START;
                    default: ns = step_t'(5'(s + 5'd1));
                endcase
            end
            if (fail || fin)
            begin
                st_next = ns; pc_next = '0; bi_next = '0; acks_next = '0;
                case (ns)
                    S_R_DEVW, S_W_DEVW, S_P_DEVW: sh_v = {cfg.dev, 1'b0};
                    S_R_DEVR: sh_v = {cfg.dev, 1'b1};
                    S_R_AHI, S_W_AHI: sh_v = addr16[15:8];
                    S_R_ALO, S_W_ALO: sh_v = addr16[7:0];
                    S_W_DATA: sh_v = (st_reg == S_IDLE) ? item.write_data : pend_reg;
                    S_R_BYTE: sh_v = '0;
                    default: ;
                endcase
            end
        end
        sh_next = sh_v; rem_next = rem_v; addr_next = addr_v; tries_next = tr_v;
        res_next.scl_out = scl_next;
        res_next.sda_out = sda_next;
        res_next.busy_res = (st_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; pc_reg <= '0; bi_reg <= '0; sh_reg <= '0;
            addr_reg <= '0; rem_reg <= '0; tries_reg <= '0; acks_reg <= '0;
            pend_reg <= '0; scl_reg <= 1'b1; sda_reg <= 1'b1; res_reg <= '0;
        end
        else if (step)
        begin
            st_reg <= st_next; pc_reg <= pc_next; bi_reg <= bi_next;
            sh_reg <= sh_next; addr_reg <= addr_next; rem_reg <= rem_next;
            tries_reg <= tries_next; acks_reg <= acks_next; pend_reg <= pend_next;
            scl_reg <= scl_next; sda_reg <= sda_next; res_reg <= res_next;
        end
    end

    `include "i2c_eeprom_master_assert.svh"
    `IEM_ASSERT_IMP(a_done_idle, clk, rst_n, res_reg.done_res, !res_reg.busy_res)
    `IEM_ASSERT_IMP(a_stat_ok, clk, rst_n, !res_reg.done_res, res_reg.status == STAT_OK)
    `IEM_ASSERT_IMP(a_byte_read, clk, rst_n, res_reg.byte_valid, res_reg.scl_out)
    `IEM_ASSERT_IMP(a_idle_lines, clk, rst_n, st_reg == S_IDLE, scl_reg && sda_reg)
endmodule

// ----- src/i2c_eeprom_master.sv -----
// A result beat is registered and shown the cycle after its tick beat is accepted.
// Throughput: one tick beat per cycle while m_tready allows; the sequencer sets it.
// Reset: asynchronous, active low; bus idle, lines released high, registers
// at their default values.
// ----------------------------------------------------------------------------
// i2c_eeprom_master
// Bit-level I2C master for 24-series EEPROMs, one bus phase per beat.
// ----------------------------------------------------------------------------
module i2c_eeprom_master
    import iem_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode[1:0], mem_addr[17:2], read_count[33:18], write_data[41:34], sda_in[42]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // scl_out, sda_out, busy_res, byte_valid, read_byte[11:4], done_res[12],
    // status[14:13]
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);
    cfg_t    cfg;
    item_t   item;
    result_t res;
    logic    vld_reg, step;

    assign item.mode = s_tdata[1:0];
    assign item.mem_addr = s_tdata[17:2];
    assign item.read_count = s_tdata[33:18];
    assign item.write_data = s_tdata[41:34];
    assign item.sda_in = s_tdata[42];

    assign s_tready = !vld_reg || m_tready;
    assign step = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vld_reg <= 1'b0;
        else if (s_tready) vld_reg <= s_tvalid;
    end

    iem_cfg_regs u_cfg (.clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data, .cfg);
    iem_engine #(.ADDRESS_BITS(ADDRESS_BITS)) u_eng
        (.clk, .rst_n, .step, .item, .cfg, .res);

    assign m_tvalid = vld_reg;
    assign m_tdata = {1'b0, res.status, res.done_res, res.read_byte,
                      res.byte_valid, res.busy_res, res.sda_out, res.scl_out};
    assign m_tlast = res.last_byte;
endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb - I2C EEPROM master testbench
// Drives phase beats with a small bus responder on SDA, predicts every result
// beat with an in-bench phase sequencer and checks the results field by field.
// ----------------------------------------------------------------------------
module tb;
    import iem_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_BEATS = 150;

    typedef enum logic [4:0] {
        ST_IDLE, ST_R_START, ST_R_DEVW, ST_R_ACK_DEVW, ST_R_AHI, ST_R_ACK_AHI,
        ST_R_ALO, ST_R_ACK_ALO, ST_R_RESTART, ST_R_DEVR, ST_R_ACK_DEVR,
        ST_R_BYTE, ST_R_MACK, ST_W_START, ST_W_DEVW, ST_W_ACK_DEVW, ST_W_AHI,
        ST_W_ACK_AHI, ST_W_ALO, ST_W_ACK_ALO, ST_W_DATA, ST_W_ACK_DATA,
        ST_P_START, ST_P_DEVW, ST_P_ACK, ST_STOP_OK, ST_STOP_TIMEOUT,
        ST_STOP_POLLFAIL, ST_STOP_RETRY_W, ST_STOP_RETRY_P
    } step_t;

    typedef enum logic [2:0] {
        PH_NONE, PH_START, PH_STOP, PH_SEND, PH_ACK, PH_READ, PH_MACK
    } phase_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_DEV;
    logic [9:0]  cfg_data = '0;

    i2c_eeprom_master u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // predicted sequencer state and registers
    logic [6:0]  dev_addr;
    logic [7:0]  ack_limit;
    logic [9:0]  poll_max;
    step_t       step;
    logic [1:0]  phase;
    logic [3:0]  bit_no;
    logic [7:0]  shreg;
    logic [15:0] cur_addr;
    logic [15:0] remaining;
    logic [9:0]  tries;
    logic [7:0]  high_samples;
    logic [7:0]  wr_byte;
    logic [1:0]  lines;

    result_t     expected_q[$];
    int          errors = 0;
    int          beats = 0;
    int          checked = 0;
    int          cycles = 0;
    int          bytes_read = 0;
    int          status_seen[3] = '{0, 0, 0};
    int          burst_left = 0;
    int          ack_pct = 100;
    bit          fast_sink = 1'b0;

    function automatic phase_kind_t kind_of(step_t s);
        case (s)
            ST_R_START, ST_R_RESTART, ST_W_START, ST_P_START: return PH_START;
            ST_R_DEVW, ST_R_AHI, ST_R_ALO, ST_R_DEVR, ST_W_DEVW, ST_W_AHI,
            ST_W_ALO, ST_W_DATA, ST_P_DEVW: return PH_SEND;
            ST_R_ACK_DEVW, ST_R_ACK_AHI, ST_R_ACK_ALO, ST_R_ACK_DEVR,
            ST_W_ACK_DEVW, ST_W_ACK_AHI, ST_W_ACK_ALO, ST_W_ACK_DATA,
            ST_P_ACK: return PH_ACK;
            ST_R_BYTE: return PH_READ;
            ST_R_MACK: return PH_MACK;
            ST_STOP_OK, ST_STOP_TIMEOUT, ST_STOP_POLLFAIL, ST_STOP_RETRY_W,
            ST_STOP_RETRY_P: return PH_STOP;
            default: return PH_NONE;
        endcase
    endfunction

    function automatic void load_step(step_t s);
        step = s;
        phase = '0;
        bit_no = '0;
        high_samples = '0;
        case (s)
            ST_R_DEVW, ST_W_DEVW, ST_P_DEVW: shreg = {dev_addr, 1'b0};
            ST_R_DEVR: shreg = {dev_addr, 1'b1};
            ST_R_AHI, ST_W_AHI: shreg = cur_addr[15:8];
            ST_R_ALO, ST_W_ALO: shreg = cur_addr[7:0];
            ST_W_DATA: shreg = wr_byte;
            ST_R_BYTE: shreg = '0;
            default: ;
        endcase
    endfunction

    function automatic step_t follow(step_t s, inout result_t r);
        case (s)
            ST_R_ACK_DEVW: return ST_R_AHI;
            ST_R_ACK_ALO: return ST_R_RESTART;
            ST_R_ACK_DEVR: return remaining != 0 ? ST_R_BYTE : ST_STOP_OK;
            ST_R_BYTE: return ST_R_MACK;
            ST_R_MACK:
            begin
                remaining = remaining - 1'b1;
                cur_addr = cur_addr + 1'b1;
                return remaining != 0 ? ST_R_BYTE : ST_STOP_OK;
            end
            ST_W_ACK_DEVW: return ST_W_AHI;
            ST_W_ACK_DATA, ST_P_ACK: return ST_STOP_OK;
            ST_STOP_OK:
            begin
                r.done_res = 1'b1;
                r.status = STAT_OK;
                return ST_IDLE;
            end
            ST_STOP_TIMEOUT:
            begin
                r.done_res = 1'b1;
                r.status = STAT_TIMEOUT;
                return ST_IDLE;
            end
            ST_STOP_POLLFAIL:
            begin
                r.done_res = 1'b1;
                r.status = STAT_POLLFAIL;
                return ST_IDLE;
            end
            ST_STOP_RETRY_W: return ST_W_START;
            ST_STOP_RETRY_P: return ST_P_START;
            default: return step_t'(s + 1'b1);
        endcase
    endfunction

    function automatic void bus_phase(logic sda_in, inout result_t r);
        logic   scl;
        logic   sda;
        step_t  s;
        logic [2:0] nxt;
        bit     fin;
        bit     fail;
        scl = lines[1];
        sda = lines[0];
        s = step;
        nxt = phase + 1'b1;
        fin = 1'b0;
        fail = 1'b0;
        case (kind_of(s))
            PH_START:
                case (phase)
                    2'd0: sda = 1'b1;
                    2'd1: scl = 1'b1;
                    2'd2: sda = 1'b0;
                    default: begin scl = 1'b0; fin = 1'b1; end
                endcase
            PH_STOP:
                case (phase)
                    2'd0: scl = 1'b0;
                    2'd1: sda = 1'b0;
                    2'd2: scl = 1'b1;
                    default: begin sda = 1'b1; fin = 1'b1; end
                endcase
            PH_SEND:
                case (phase)
                    2'd0: begin scl = 1'b0; sda = shreg[7]; end
                    2'd1: scl = 1'b1;
                    2'd2:
                    begin
                        scl = 1'b0;
                        if (bit_no < 7)
                        begin
                            shreg = shreg << 1;
                            bit_no++;
                            nxt = 3'd0;
                        end
                    end
                    default: begin sda = 1'b1; fin = 1'b1; end
                endcase
            PH_ACK:
                if (phase == 2'd0)
                    sda = 1'b1;
                else if (phase == 2'd1)
                begin
                    scl = 1'b1;
                    sda = 1'b1;
                    if (!sda_in)
                        nxt = 3'd2;
                    else if (high_samples >= ack_limit)
                        fail = 1'b1;
                    else
                    begin
                        high_samples++;
                        nxt = 3'd1;
                    end
                end
                else
                begin
                    scl = 1'b0;
                    fin = 1'b1;
                end
            PH_READ:
                if (phase == 2'd0)
                begin
                    scl = 1'b1;
                    sda = 1'b1;
                    shreg = {shreg[6:0], sda_in};
                    if (bit_no >= 7)
                    begin
                        r.byte_valid = 1'b1;
                        r.read_byte = shreg;
                        r.last_byte = remaining == 16'd1;
                    end
                end
                else
                begin
                    scl = 1'b0;
                    if (bit_no < 7)
                    begin
                        bit_no++;
                        nxt = 3'd0;
                    end
                    else
                        fin = 1'b1;
                end
            PH_MACK:
                if (remaining > 1)
                    case (phase)
                        2'd0: sda = 1'b0;
                        2'd1: scl = 1'b1;
                        2'd2: scl = 1'b0;
                        default: begin sda = 1'b1; fin = 1'b1; end
                    endcase
                else if (phase == 2'd0)
                    sda = 1'b1;
                else if (phase == 2'd1)
                    scl = 1'b1;
                else
                begin
                    scl = 1'b0;
                    fin = 1'b1;
                end
            default:
            begin
                load_step(ST_IDLE);
                return;
            end
        endcase
        lines = {scl, sda};
        phase = nxt[1:0];
        if (fail)
        begin
            // a failed poll try is retried until the try budget runs out
            if (s == ST_W_ACK_DEVW || s == ST_P_ACK)
            begin
                tries++;
                if (tries >= poll_max)
                    load_step(ST_STOP_POLLFAIL);
                else
                    load_step(s == ST_W_ACK_DEVW ? ST_STOP_RETRY_W : ST_STOP_RETRY_P);
            end
            else
                load_step(ST_STOP_TIMEOUT);
        end
        else if (fin)
            load_step(follow(s, r));
    endfunction

    function automatic result_t predict_phase(item_t it);
        result_t r;
        r = '0;
        if (step == ST_IDLE)
        begin
            if (it.mode != MODE_TICK)
            begin
                cur_addr = it.mem_addr;
                remaining = it.read_count;
                wr_byte = it.write_data;
                tries = '0;
                load_step(it.mode == MODE_READ ? ST_R_START :
                          it.mode == MODE_WRITE ? ST_W_START : ST_P_START);
                bus_phase(it.sda_in, r);
            end
        end
        else
            bus_phase(it.sda_in, r);
        r.scl_out = lines[1];
        r.sda_out = lines[0];
        r.busy_res = step != ST_IDLE;
        return r;
    endfunction

    // responder: acks with the set likelihood, random data on read bits
    function automatic logic pick_sda();
        if (kind_of(step) == PH_ACK && phase == 2'd1)
            return $urandom_range(99, 0) >= ack_pct;
        return 1'($urandom_range(1, 0));
    endfunction

    // called just after a rising edge; leaves the caller just after one
    task automatic send_beat(item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(6, 1);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(40, 1);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, it.sda_in, it.write_data, it.read_count, it.mem_addr, it.mode};
        do
            @(posedge clk);
        while (!s_tready);
        expected_q.push_back(predict_phase(it));
        beats++;
    endtask

    function automatic item_t random_item();
        item_t it;
        it.mode = 2'($urandom_range(3, 0));
        it.mem_addr = 16'($urandom);
        it.read_count = 16'($urandom);
        it.write_data = 8'($urandom);
        it.sda_in = 1'($urandom_range(1, 0));
        return it;
    endfunction

    task automatic run_request(logic [1:0] mode, logic [15:0] addr, logic [15:0] count,
                               logic [7:0] data);
        item_t it;
        it.mode = mode;
        it.mem_addr = addr;
        it.read_count = count;
        it.write_data = data;
        it.sda_in = pick_sda();
        send_beat(it);
        // requests arriving while busy are ignored, so tick content is random
        while (step != ST_IDLE)
        begin
            it = random_item();
            it.sda_in = pick_sda();
            send_beat(it);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [9:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_DEV: dev_addr = value[6:0];
            REG_ACKTO: ack_limit = value[7:0];
            default: poll_max = value;
        endcase
    endtask

    task automatic report(string field, int got, int want);
        errors++;
        $display("mismatch on beat %0d: %s got %0h expected %0h",
                 checked, field, got, want);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        cycles++;
        if (m_tvalid && m_tready)
        begin
            checked++;
            if (expected_q.size() == 0)
                report("unexpected beat", m_tdata, 0);
            else
            begin
                want = expected_q.pop_front();
                if (m_tdata[0] !== want.scl_out) report("scl_out", m_tdata[0], want.scl_out);
                if (m_tdata[1] !== want.sda_out) report("sda_out", m_tdata[1], want.sda_out);
                if (m_tdata[2] !== want.busy_res) report("busy_res", m_tdata[2], want.busy_res);
                if (m_tdata[3] !== want.byte_valid)
                    report("byte_valid", m_tdata[3], want.byte_valid);
                if (m_tdata[11:4] !== want.read_byte)
                    report("read_byte", m_tdata[11:4], want.read_byte);
                if (m_tlast !== want.last_byte) report("last_byte", m_tlast, want.last_byte);
                if (m_tdata[12] !== want.done_res) report("done_res", m_tdata[12], want.done_res);
                if (m_tdata[14:13] !== want.status) report("status", m_tdata[14:13], want.status);
                if (want.byte_valid)
                    bytes_read++;
                if (want.done_res)
                    status_seen[want.status]++;
            end
        end
        if (cycles % 300 == 0)
            fast_sink <= ~fast_sink;
        m_tready <= fast_sink ? 1'b1 : ($urandom_range(3, 0) != 0);
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("i2c_eeprom_master test failed");
            $finish;
        end
    end

    task automatic test_defaults();
        ack_pct = 100;
        run_request(MODE_READ, 16'hFFFF, 16'd2, 8'h00);
        run_request(MODE_WRITE, 16'h0000, 16'hFFFF, 8'hFF);
        run_request(MODE_POLL, 16'h8001, 16'h0000, 8'h00);
    endtask

    task automatic test_register_extremes();
        write_reg(REG_DEV, 10'h3FF);
        write_reg(REG_ACKTO, 10'd1);
        write_reg(REG_POLL, 10'd1023);
        ack_pct = 70;
        run_request(MODE_READ, 16'h1234, 16'd1, 8'h00);
        run_request(MODE_POLL, 16'hFFFF, 16'd0, 8'h00);
        write_reg(REG_DEV, 10'd0);
        write_reg(REG_ACKTO, 10'd0);
        ack_pct = 100;
        run_request(MODE_READ, 16'h0000, 16'd0, 8'hA5);
    endtask

    task automatic test_ack_timeout();
        write_reg(REG_ACKTO, 10'd255);
        ack_pct = 0;
        run_request(MODE_READ, 16'h00FF, 16'd3, 8'h00);
        write_reg(REG_ACKTO, 10'd2);
        run_request(MODE_READ, 16'hFF00, 16'd1, 8'h00);
    endtask

    task automatic test_poll_exhaust();
        write_reg(REG_POLL, 10'd2);
        ack_pct = 0;
        run_request(MODE_WRITE, 16'h5555, 16'd1, 8'h5A);
        run_request(MODE_POLL, 16'hAAAA, 16'd1, 8'h00);
        write_reg(REG_POLL, 10'd0);
        run_request(MODE_POLL, 16'h0001, 16'd1, 8'h00);
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int pick;
        item_t tick;
        stop_at = beats + RANDOM_BEATS;
        while (beats < stop_at)
        begin
            if ($urandom_range(5, 0) == 0)
            begin
                write_reg(REG_DEV, 10'($urandom));
                write_reg(REG_ACKTO, 10'($urandom_range(6, 0)));
                write_reg(REG_POLL, 10'($urandom_range(4, 1)));
            end
            pick = $urandom_range(9, 0);
            ack_pct = pick < 7 ? 95 : (pick < 9 ? 45 : 0);
            if ($urandom_range(7, 0) == 0)
            begin
                tick = random_item();
                tick.mode = MODE_TICK;
                send_beat(tick);
            end
            run_request(2'($urandom_range(3, 1)), 16'($urandom),
                        16'(($urandom_range(9, 0) == 0) ? $urandom_range(8, 0)
                                                        : $urandom_range(3, 0)),
                        8'($urandom));
        end
    endtask

    initial
    begin
        dev_addr = DEV_ADDR_RST;
        ack_limit = ACK_TO_RST;
        poll_max = POLL_LIM_RST;
        load_step(ST_IDLE);
        shreg = '0;
        cur_addr = '0;
        remaining = '0;
        tries = '0;
        wr_byte = '0;
        lines = 2'b11;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_register_extremes();
        test_ack_timeout();
        test_poll_exhaust();
        test_random_traffic();
        drain();
        $display("covered %0d phase beats, %0d bytes read", beats, bytes_read);
        $display("transactions ended ok %0d, ack timeout %0d, poll exhausted %0d",
                 status_seen[0], status_seen[1], status_seen[2]);
        if (errors == 0)
            $display("i2c_eeprom_master test passed");
        else
            $display("i2c_eeprom_master test failed");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+src
src/iem_pkg.sv
src/iem_cfg_regs.sv
src/iem_engine.sv
src/i2c_eeprom_master.sv
tb/sv/tb.sv
